### hdl/spfa_pkg.sv
// Package for the single-precision same-sign float adder.
// Item types and field widths; no dependencies.
package spfa_pkg;
  localparam int FracBits  = 23;
  localparam int SigBits   = 24;
  localparam int ExtraBits = 3;
  localparam int AccBits   = SigBits + ExtraBits + 1;

  typedef struct packed {
    logic [31:0] operand_a;
    logic [31:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic [31:0] sum;
    logic        overflowed;
    logic        unsupported;
  } out_item_t;
endpackage

### hdl/single_precision_float_adder.sv
// Single-precision same-sign float adder: four-stage pipeline.
// One item per cycle sustained while the output is not stalled.
// Stages: order, align, add and normalize, round. A stall freezes the full stages, with
// an empty stage filling while the output waits (stall only blocks the input
// when the pipe is full).
// Reset (rst_ni low, asynchronous) clears all stage valid bits.
module single_precision_float_adder (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  spfa_pkg::in_item_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output spfa_pkg::out_item_t   out_data_o
);
  import spfa_pkg::*;

  // stage valids and advance enables
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;
  assign en4 = !v4_q || !out_stall_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  // stage 1: unpack, order, exponent difference
  logic        s1_sign_q, s1_uns_q;
  logic [7:0]  s1_exp_q, s1_d_q;
  logic [23:0] s1_big_q, s1_small_q;
  logic [7:0]  ea, eb;
  logic        uns;
  assign ea  = in_data_i.operand_a[30:23];
  assign eb  = in_data_i.operand_b[30:23];
  assign uns = (in_data_i.operand_a[31] != in_data_i.operand_b[31]) || ea == 8'd0
            || ea == 8'hFF || eb == 8'd0 || eb == 8'hFF;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_sign_q <= in_data_i.operand_a[31];
      s1_uns_q  <= uns;
      if (ea >= eb) begin
        s1_exp_q   <= ea;
        s1_d_q     <= ea - eb;
        s1_big_q   <= {1'b1, in_data_i.operand_a[22:0]};
        s1_small_q <= {1'b1, in_data_i.operand_b[22:0]};
      end else begin
        s1_exp_q   <= eb;
        s1_d_q     <= eb - ea;
        s1_big_q   <= {1'b1, in_data_i.operand_b[22:0]};
        s1_small_q <= {1'b1, in_data_i.operand_a[22:0]};
      end
    end
  end

  // stage 2: align smaller significand with sticky
  logic        s2_sign_q, s2_uns_q;
  logic [7:0]  s2_exp_q;
  logic [26:0] s2_big_q, s2_sh_q;
  logic [26:0] small_x, sh_v, lost_mask;
  assign small_x = {s1_small_q, 3'b000};
  always_comb begin
    if (s1_d_q < 8'(SigBits + ExtraBits)) begin
      sh_v      = small_x >> s1_d_q[4:0];
      lost_mask = ~(27'h7FFFFFF << s1_d_q[4:0]);
      sh_v[0]   = sh_v[0] | (|(small_x & lost_mask));
    end else begin
      lost_mask = '0;
      sh_v      = 27'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_sign_q <= s1_sign_q;
      s2_uns_q  <= s1_uns_q;
      s2_exp_q  <= s1_exp_q;
      s2_big_q  <= {s1_big_q, 3'b000};
      s2_sh_q   <= sh_v;
    end
  end

  // stage 3: add and renormalize on carry
  logic        s3_sign_q, s3_uns_q;
  logic [8:0]  s3_exp_q;
  logic [26:0] s3_acc_q;
  logic [27:0] acc;
  assign acc = {1'b0, s2_big_q} + {1'b0, s2_sh_q};
  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_sign_q <= s2_sign_q;
      s3_uns_q  <= s2_uns_q;
      if (acc[27]) begin
        s3_acc_q <= {acc[27:2], acc[1] | acc[0]};
        s3_exp_q <= {1'b0, s2_exp_q} + 9'd1;
      end else begin
        s3_acc_q <= acc[26:0];
        s3_exp_q <= {1'b0, s2_exp_q};
      end
    end
  end

  // stage 4: round to nearest even, pack
  logic [24:0] mant_r;
  logic [8:0]  exp_r;
  logic [23:0] mant;
  logic        up;
  out_item_t   res, out_q;
  assign mant = s3_acc_q[26:3];
  assign up   = s3_acc_q[2] && (s3_acc_q[1] || s3_acc_q[0] || mant[0]);
  always_comb begin
    mant_r = {1'b0, mant} + {24'd0, up};
    exp_r  = s3_exp_q;
    if (mant_r[24]) begin
      mant_r = mant_r >> 1;
      exp_r  = s3_exp_q + 9'd1;
    end
    res = '0;
    if (s3_uns_q) begin
      res.unsupported = 1'b1;
    end else if (exp_r >= 9'd255) begin
      res.sum        = {s3_sign_q, 8'hFF, 23'd0};
      res.overflowed = 1'b1;
    end else begin
      res.sum = {s3_sign_q, exp_r[7:0], mant_r[22:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = out_q;
endmodule
